@@ rtl/core/card_marking_bump_allocator_macros.svh @@
// assertion macros for the card marking bump allocator
// expects clk and rst_n in the including module
`ifndef CARD_MARKING_BUMP_ALLOCATOR_MACROS_SVH
`define CARD_MARKING_BUMP_ALLOCATOR_MACROS_SVH

// condition holds at every edge out of reset
`define CMBA_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define CMBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/cmba_pkg.sv @@
// shared types and constants for the card marking bump allocator
// no dependencies
`default_nettype none

package cmba_pkg;

    localparam int unsigned HEAP_BYTES_DEF  = 1048576;
    localparam int unsigned CARD_BYTES_DEF  = 512;
    localparam int unsigned ALIGN_BYTES_DEF = 64;

    // card bits are stored in rows of this many cards
    localparam int ROW_BITS  = 32;
    localparam int ROW_SHIFT = 5;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic REG_HEAP_BASE = 1'b0;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_MARK  = 2'd1,
        OP_QUERY = 2'd2,
        OP_CLEAR = 2'd3
    } cmba_op_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_IGNORED   = 2'd1,
        ST_EXHAUSTED = 2'd2
    } cmba_status_t;

    typedef struct packed {
        cmba_op_t    opcode;
        logic [31:0] address;
        logic [31:0] request_bytes;
    } cmba_req_t;

    typedef struct packed {
        logic [31:0]  alloc_address;
        logic         card_dirty;
        cmba_status_t status;
    } cmba_rsp_t;

endpackage

`default_nettype wire

@@ rtl/core/card_marking_bump_allocator.sv @@
// card marking write barrier with bump allocator, top level
// depends on cmba_pkg and card_marking_bump_allocator_macros.svh
//
// One request beat is accepted per cycle while the response does not stall; its response beat
// passes the input register, then card row read and size rounding, then state update into the
// response register, and a stalled response holds the whole pipe. CARD_BYTES must be a power
// of two, ALIGN_BYTES may be any value in range. Card bits live in a row memory of 32 cards per
// row with one valid flip-flop per row, so reset and clear-all need no clearing pass. heap_base
// is written through the APB port, by the user only while idle; the block does not enforce it.
`default_nettype none
`include "card_marking_bump_allocator_macros.svh"

module card_marking_bump_allocator
    import cmba_pkg::*;
#(
    parameter int unsigned HEAP_BYTES  = HEAP_BYTES_DEF,
    parameter int unsigned CARD_BYTES  = CARD_BYTES_DEF,
    parameter int unsigned ALIGN_BYTES = ALIGN_BYTES_DEF
)(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,

    input  logic               req_valid,
    output logic               req_ready,
    input  cmba_req_t          req,

    output logic               rsp_valid,
    input  logic               rsp_ready,
    output cmba_rsp_t          rsp
);

    localparam int USED_W       = $clog2(HEAP_BYTES + 1);
    localparam int NUM_CARDS    = (HEAP_BYTES + CARD_BYTES - 1) / CARD_BYTES;
    localparam int CARD_SHIFT   = $clog2(CARD_BYTES);
    localparam int NUM_ROWS     = (NUM_CARDS + ROW_BITS - 1) / ROW_BITS;
    localparam int ROW_W        = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int IDX_W        = ROW_W + ROW_SHIFT;
    localparam int ALIGN_LOG    = $clog2(ALIGN_BYTES);
    localparam int RECIP_SHIFT  = 31 + ALIGN_LOG;
    localparam longint unsigned RECIP_L =
        ((longint'(1) << RECIP_SHIFT) + longint'(ALIGN_BYTES) - 1) / longint'(ALIGN_BYTES);
    localparam logic [31:0]       RECIP     = 32'(RECIP_L);
    localparam logic [USED_W-1:0] HEAP_FULL = USED_W'(HEAP_BYTES);

    // configuration
    logic [31:0] heap_base_reg;
    logic [31:0] heap_base_next;
    logic        cfg_sel;

    // pipeline control
    logic advance;
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic rsp_valid_reg, rsp_valid_next;

    // stage 1
    cmba_req_t         s1_reg;
    logic [33:0]       s1_heap_end;
    logic              s1_in_heap;
    logic [31:0]       s1_offset;
    logic [IDX_W-1:0]  s1_idx;
    logic [ROW_W-1:0]  s1_row;
    logic              s1_zero;
    logic              s1_big;
    logic [30:0]       s1_sum;
    logic [62:0]       s1_prod;
    logic [USED_W-1:0] s1_q;
    logic              s1_fwd;
    logic              s1_row_ok;

    // stage 2
    cmba_op_t          s2_op_reg;
    logic              s2_in_heap_reg;
    logic [IDX_W-1:0]  s2_idx_reg;
    logic              s2_zero_reg;
    logic              s2_big_reg;
    logic [USED_W-1:0] s2_q_reg;
    logic              s2_fwd_reg;
    logic              s2_row_ok_reg;
    logic [ROW_BITS-1:0] rd_row_reg;
    logic [USED_W-1:0] s2_avail;
    logic [31:0]       s2_rounded;
    logic              s2_fits;
    logic              alloc_ok;
    logic              mark_ok;
    logic              s2_dirty;
    logic [IDX_W-1:0]  alloc_idx;
    cmba_rsp_t         s2_rsp;

    // state
    logic [USED_W-1:0]   used_reg, used_next;
    logic [NUM_ROWS-1:0] row_valid_reg, row_valid_next;
    logic [ROW_BITS-1:0] card_mem [NUM_ROWS];
    cmba_rsp_t           rsp_reg;

    // card write port
    logic                wr_en;
    logic                clr_now;
    logic [IDX_W-1:0]    wr_idx;
    logic [ROW_W-1:0]    wr_row;
    logic [ROW_BITS-1:0] wr_onehot;
    logic [ROW_BITS-1:0] wr_mask;

    // apb
    assign pready  = 1'b1;
    assign cfg_sel = (paddr[PADDR_W-1:2] == REG_HEAP_BASE);
    assign prdata  = cfg_sel ? heap_base_reg : '0;

    always_comb
    begin
        heap_base_next = heap_base_reg;
        if (psel && penable && pwrite && cfg_sel)
        begin
            heap_base_next = pwdata;
        end
    end

    // handshake
    assign advance   = !rsp_valid_reg || rsp_ready;
    assign req_ready = advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign s1_valid_next  = advance ? req_valid : s1_valid_reg;
    assign s2_valid_next  = advance ? s1_valid_reg : s2_valid_reg;
    assign rsp_valid_next = advance ? s2_valid_reg : rsp_valid_reg;

    // stage 1: address decode, card row read, size rounding
    assign s1_heap_end = {2'b00, heap_base_reg} + 34'(HEAP_BYTES);
    assign s1_in_heap  = (s1_reg.address != '0) && (s1_reg.address >= heap_base_reg)
                         && ({2'b00, s1_reg.address} < s1_heap_end);
    assign s1_offset   = s1_reg.address - heap_base_reg;
    assign s1_idx      = IDX_W'(s1_offset >> CARD_SHIFT);
    assign s1_row      = s1_idx[IDX_W-1:ROW_SHIFT];
    assign s1_zero     = (s1_reg.request_bytes == '0);
    assign s1_big      = (s1_reg.request_bytes > 32'(HEAP_BYTES));
    assign s1_sum      = s1_reg.request_bytes[30:0] + 31'(ALIGN_BYTES - 1);
    assign s1_prod     = 63'(s1_sum) * 63'(RECIP);
    assign s1_q        = USED_W'(s1_prod >> RECIP_SHIFT);

    // bypass of the card write at the same edge
    assign s1_fwd    = wr_en && (wr_idx == s1_idx);
    assign s1_row_ok = row_valid_reg[s1_row] && !clr_now;

    // stage 2: fit check and state update
    assign s2_avail   = HEAP_FULL - used_reg;
    assign s2_rounded = 32'(s2_q_reg) * 32'(ALIGN_BYTES);
    assign s2_fits    = !s2_big_reg && (s2_rounded <= 32'(s2_avail));
    assign alloc_ok   = s2_valid_reg && (s2_op_reg == OP_ALLOC) && !s2_zero_reg && s2_fits;
    assign mark_ok    = s2_valid_reg && (s2_op_reg == OP_MARK) && s2_in_heap_reg;
    assign alloc_idx  = IDX_W'(used_reg >> CARD_SHIFT);
    assign s2_dirty   = s2_fwd_reg
                        || (s2_row_ok_reg && rd_row_reg[s2_idx_reg[ROW_SHIFT-1:0]]);

    assign wr_en     = advance && (alloc_ok || mark_ok);
    assign clr_now   = advance && s2_valid_reg && (s2_op_reg == OP_CLEAR);
    assign wr_idx    = alloc_ok ? alloc_idx : s2_idx_reg;
    assign wr_row    = wr_idx[IDX_W-1:ROW_SHIFT];
    assign wr_onehot = ROW_BITS'(1) << wr_idx[ROW_SHIFT-1:0];
    // a row that is not valid is rewritten whole so its stale bits read as clean
    assign wr_mask   = row_valid_reg[wr_row] ? wr_onehot : '1;

    assign used_next = (advance && alloc_ok) ? used_reg + USED_W'(s2_rounded) : used_reg;

    always_comb
    begin
        row_valid_next = row_valid_reg;
        if (clr_now)
        begin
            row_valid_next = '0;
        end
        else if (wr_en)
        begin
            row_valid_next = row_valid_reg | (NUM_ROWS'(1) << wr_row);
        end
    end

    always_comb
    begin
        s2_rsp = '{alloc_address: '0, card_dirty: 1'b0, status: ST_DONE};
        unique case (s2_op_reg)
            OP_ALLOC:
            begin
                if (s2_zero_reg)
                begin
                    s2_rsp.status = ST_IGNORED;
                end
                else if (!s2_fits)
                begin
                    s2_rsp.status = ST_EXHAUSTED;
                end
                else
                begin
                    s2_rsp.alloc_address = heap_base_reg + 32'(used_reg);
                end
            end
            OP_MARK:
            begin
                if (!s2_in_heap_reg)
                begin
                    s2_rsp.status = ST_IGNORED;
                end
            end
            OP_QUERY:
            begin
                if (s2_in_heap_reg)
                begin
                    s2_rsp.card_dirty = s2_dirty;
                end
                else
                begin
                    s2_rsp.status = ST_IGNORED;
                end
            end
            OP_CLEAR:
            begin
                s2_rsp.status = ST_DONE;
            end
            default:
            begin
                s2_rsp.status = ST_DONE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            used_reg      <= '0;
            row_valid_reg <= '0;
        end
        else
        begin
            heap_base_reg <= heap_base_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            used_reg      <= used_next;
            row_valid_reg <= row_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (req_valid)
            begin
                s1_reg <= req;
            end
            s2_op_reg      <= s1_reg.opcode;
            s2_in_heap_reg <= s1_in_heap;
            s2_idx_reg     <= s1_idx;
            s2_zero_reg    <= s1_zero;
            s2_big_reg     <= s1_big;
            s2_q_reg       <= s1_q;
            s2_fwd_reg     <= s1_fwd;
            s2_row_ok_reg  <= s1_row_ok;
            rsp_reg        <= s2_rsp;
        end
    end

    // card row memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            for (int b = 0; b < ROW_BITS; b++)
            begin
                if (wr_mask[b])
                begin
                    card_mem[wr_row][b] <= wr_onehot[b];
                end
            end
        end
        if (advance)
        begin
            rd_row_reg <= card_mem[s1_row];
        end
    end

    `CMBA_ASSERT_ALWAYS(a_used_bound, used_reg <= HEAP_FULL, "bytes in use exceed heap size")
    `CMBA_ASSERT_NEXT(a_clear_rows, clr_now, row_valid_reg == '0, "card rows valid after clear")
    `CMBA_ASSERT_NEXT(a_alloc_grows, wr_en && alloc_ok, used_reg != $past(used_reg), "no growth")
    `CMBA_ASSERT_ALWAYS(a_dirty, !rsp_valid || !rsp.card_dirty || rsp.status == ST_DONE, "bad dirty")

endmodule

`default_nettype wire
